// ===== hdl/bfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants of the binary frame receiver.
// ----------------------------------------------------------------------------
package bfr_pkg;

   // request op codes
   localparam logic [1:0] BFR_OP_BYTE = 2'd0;
   localparam logic [1:0] BFR_OP_TICK = 2'd1;
   localparam logic [1:0] BFR_OP_READ = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] BFR_REG_SYNC_FIRST    = 2'd0;
   localparam logic [1:0] BFR_REG_SYNC_SECOND   = 2'd1;
   localparam logic [1:0] BFR_REG_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0]  BFR_SYNC_FIRST_RST    = 8'hA5;
   localparam logic [7:0]  BFR_SYNC_SECOND_RST   = 8'h5A;
   localparam logic [15:0] BFR_TIMEOUT_TICKS_RST = 16'd0;

   // position / long-form length register width
   localparam int unsigned BFR_POS_W = 15;
   localparam logic [15:0] BFR_TICK_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      BFR_HUNT     = 4'd0,
      BFR_SYNC2    = 4'd1,
      BFR_LEN      = 4'd2,
      BFR_LEN2     = 4'd3,
      BFR_PAYLOAD  = 4'd4,
      BFR_CHECK    = 4'd5,
      BFR_COMPLETE = 4'd6,
      BFR_ERROR    = 4'd7,
      BFR_CKERROR  = 4'd8
   } state_type;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // parser outcome for one request, loaded into the response register
   typedef struct packed {
      logic [3:0]  status;
      logic [10:0] frame_length;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/bfr_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_store
// Payload buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfr_store #(
   parameter int unsigned MAX_PAYLOAD = 1024,
   parameter int unsigned AW          = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data_ff
);

   logic [7:0] mem [MAX_PAYLOAD];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bfr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_parser
// Frame parser state machine, inactivity timer and running checksum.
// ----------------------------------------------------------------------------
module bfr_parser #(
   parameter int unsigned MAX_PAYLOAD = 1024,
   parameter int unsigned AW          = 10,
   parameter int unsigned LEN_W       = 11
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [1:0]      op,
   input  wire logic [7:0]      rx_byte,
   input  wire bfr_pkg::cfg_type cfg,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [7:0]           wr_data,
   output bfr_pkg::result_type  result
);

   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   bfr_pkg::state_type           state_ff, state_in, cur;
   logic [bfr_pkg::BFR_POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [7:0]                   xor_ff, xor_in;
   logic [15:0]                  elapsed_ff, elapsed_in;
   logic                         take_len;
   logic [bfr_pkg::BFR_POS_W-1:0] len_cand;
   logic [15:0]                  len_cand_ext;
   logic [15:0]                  len_ext, len_in_ext;
   logic [15:0]                  pos_inc;
   logic                         timed_out;

   assign len_ext      = 16'(len_ff);
   assign len_in_ext   = 16'(len_in);
   assign len_cand_ext = 16'(len_cand);
   assign pos_inc      = 16'(pos_ff) + 16'd1;
   assign timed_out    = (cfg.timeout_ticks != 16'd0) && (elapsed_ff >= cfg.timeout_ticks);

   assign wr_addr = pos_ff[AW-1:0];
   assign wr_data = rx_byte;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      xor_in     = xor_ff;
      elapsed_in = elapsed_ff;
      wr_en      = 1'b0;
      take_len   = 1'b0;
      len_cand   = '0;
      cur        = state_ff;
      if (step) begin
         case (op)
            bfr_pkg::BFR_OP_BYTE: begin
               if (timed_out) begin
                  cur = bfr_pkg::BFR_HUNT;
               end
               // a finished frame: this byte is hunted like any other
               if (cur inside {bfr_pkg::BFR_COMPLETE, bfr_pkg::BFR_ERROR,
                               bfr_pkg::BFR_CKERROR}) begin
                  cur = bfr_pkg::BFR_HUNT;
               end
               state_in = cur;
               case (cur)
                  bfr_pkg::BFR_HUNT: begin
                     if (rx_byte == cfg.sync_first) begin
                        state_in   = bfr_pkg::BFR_SYNC2;
                        elapsed_in = 16'd0;
                     end
                  end
                  bfr_pkg::BFR_SYNC2: begin
                     state_in = (rx_byte == cfg.sync_second) ? bfr_pkg::BFR_LEN
                                                             : bfr_pkg::BFR_ERROR;
                  end
                  bfr_pkg::BFR_LEN: begin
                     if (rx_byte[7]) begin
                        pos_in   = {8'd0, rx_byte[6:0]};
                        state_in = bfr_pkg::BFR_LEN2;
                     end else begin
                        take_len = 1'b1;
                        len_cand = {8'd0, rx_byte[6:0]};
                     end
                  end
                  bfr_pkg::BFR_LEN2: begin
                     take_len = 1'b1;
                     len_cand = {pos_ff[6:0], rx_byte};
                  end
                  bfr_pkg::BFR_PAYLOAD: begin
                     wr_en  = (16'(pos_ff) < MaxLen);
                     xor_in = xor_ff ^ rx_byte;
                     if (pos_inc >= len_ext) begin
                        state_in = bfr_pkg::BFR_CHECK;
                     end
                     pos_in = pos_inc[bfr_pkg::BFR_POS_W-1:0];
                  end
                  bfr_pkg::BFR_CHECK: begin
                     state_in = (rx_byte == xor_ff) ? bfr_pkg::BFR_COMPLETE
                                                    : bfr_pkg::BFR_CKERROR;
                  end
                  default: begin
                     state_in = bfr_pkg::BFR_HUNT;
                  end
               endcase
               if (take_len) begin
                  // zero or oversize length: keep the old length
                  if (len_cand_ext == 16'd0 || len_cand_ext > MaxLen) begin
                     state_in = bfr_pkg::BFR_ERROR;
                  end else begin
                     len_in   = len_cand_ext[LEN_W-1:0];
                     pos_in   = '0;
                     xor_in   = 8'd0;
                     state_in = bfr_pkg::BFR_PAYLOAD;
                  end
               end
            end
            bfr_pkg::BFR_OP_TICK: begin
               if (elapsed_ff != bfr_pkg::BFR_TICK_MAX) begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign result.status       = state_in;
   assign result.frame_length = len_in_ext[10:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bfr_pkg::BFR_HUNT;
         pos_ff     <= '0;
         len_ff     <= '0;
         xor_ff     <= 8'd0;
         elapsed_ff <= 16'd0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         xor_ff     <= xor_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // checksum byte is only ever expected straight after the payload
   a_check_from_payload : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfr_pkg::BFR_CHECK && !$past(reset)
       && $past(state_ff) != bfr_pkg::BFR_CHECK)
      |-> $past(state_ff) == bfr_pkg::BFR_PAYLOAD)
      else $error("check state entered from outside payload");

   a_pos_below_len : assert property (@(posedge clock) disable iff (reset)
      state_ff == bfr_pkg::BFR_PAYLOAD |-> 16'(pos_ff) < len_ext)
      else $error("payload position ran past frame length");

   a_ticks_monotonic : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && elapsed_ff < $past(elapsed_ff)) |-> elapsed_ff == 16'd0)
      else $error("tick counter went back without a restart");

endmodule
`default_nettype wire

// ===== hdl/binary_frame_receiver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_frame_receiver_top
// Sync-hunting frame parser with length, stored payload and XOR checksum.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                       tuser
//  req_     in   rx_byte[7:0] read_index[17:8]           op[1:0]
//  rsp_     out  status[3:0] frame_length[14:4]           -
//                read_data[22:15]
//  csr_     in   we, index 0 sync_first / 1 sync_second / 2 timeout_ticks
//
//  One request per cycle while req_tready is high; its response is valid in the
//  cycle after acceptance. The response register is the only stage: a request
//  is taken whenever it is empty or being drained in the same cycle.
//  Reads come through the registered read port of the payload buffer.
//  Synchronous reset clears the parser and the response valid flag and loads
//  the csr registers with their reset values; the buffer is not cleared and
//  needs no clearing pass.
module binary_frame_receiver_top #(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // rx_byte[7:0], read_index[17:8]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // status[3:0], frame_length[14:4], read_data[22:15]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int unsigned AW    = $clog2(MAX_PAYLOAD);
   localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   bfr_pkg::cfg_type    cfg_ff;
   bfr_pkg::result_type result;
   bfr_pkg::result_type rsp_result_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic                accept;
   logic [7:0]          rx_byte;
   logic [9:0]          read_index;
   logic [15:0]         idx_ext;
   logic                rd_en;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [7:0]          wr_data;
   logic [7:0]          rd_data;
   logic [7:0]          read_data;

   assign rx_byte    = req_tdata[7:0];
   assign read_index = req_tdata[17:8];
   assign idx_ext    = 16'(read_index);

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   assign rd_en        = accept && (req_tuser == bfr_pkg::BFR_OP_READ) && (idx_ext < MaxLen);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= bfr_pkg::BFR_SYNC_FIRST_RST;
         cfg_ff.sync_second   <= bfr_pkg::BFR_SYNC_SECOND_RST;
         cfg_ff.timeout_ticks <= bfr_pkg::BFR_TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            bfr_pkg::BFR_REG_SYNC_FIRST:    cfg_ff.sync_first    <= csr_wdata[7:0];
            bfr_pkg::BFR_REG_SYNC_SECOND:   cfg_ff.sync_second   <= csr_wdata[7:0];
            bfr_pkg::BFR_REG_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW),
      .LEN_W       (LEN_W)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .op      (req_tuser),
      .rx_byte (rx_byte),
      .cfg     (cfg_ff),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .result  (result)
   );

   bfr_store #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (idx_ext[AW-1:0]),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_result_ff <= result;
         rsp_hit_ff    <= rd_en;
      end
   end

   // read data is only meaningful for an in-range read request
   assign read_data  = rsp_hit_ff ? rd_data : 8'd0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, read_data, rsp_result_ff.frame_length, rsp_result_ff.status};

   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no response");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary frame receiver. Requests are pushed in
// bursts while the response side stalls on a rotating pattern. Every accepted
// request runs through a local frame parser that predicts the status, length
// and read-back byte. A short directed walk comes first, then random frames
// and noise under several sync and timeout settings, including the extremes.
// ----------------------------------------------------------------------------
module testbench;

   localparam int         MAX_PAYLOAD = 1024;
   localparam logic [1:0] OP_UNUSED   = 2'd3;   // no function, reports status and length only
   localparam int         N_DIRECTED  = 24;

   typedef struct packed {
      logic [3:0]  status;
      logic [10:0] frame_length;
      logic [7:0]  read_data;
   } frame_report_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         rx;
      logic [9:0]         idx;
      logic               typed;     // expected values given in the row
      bfr_pkg::state_type status;
      logic [10:0]        length;
      logic [7:0]         data;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   always #1 clock = ~clock;

   binary_frame_receiver_top #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // local parser state
   bfr_pkg::cfg_type   cfg;
   bfr_pkg::state_type p_state;
   logic [14:0] p_pos;
   logic [10:0] p_len;
   logic [7:0]  p_xor;
   logic [15:0] p_ticks;
   logic [7:0]  p_store [MAX_PAYLOAD];
   int          store_top;          // entries 0 .. store_top-1 have been written

   frame_report_type expected_reports [$];
   logic             typed_valid;
   frame_report_type typed_report;
   int               fault_count;
   int               item_count;
   int               burst_left;
   step_row_type     directed_rows [N_DIRECTED];

   task automatic take_length(input int len);
      if (len == 0 || len > MAX_PAYLOAD) begin
         p_state = bfr_pkg::BFR_ERROR;
      end else begin
         p_len   = 11'(len);
         p_pos   = '0;
         p_xor   = '0;
         p_state = bfr_pkg::BFR_PAYLOAD;
      end
   endtask

   task automatic parse_step(input logic [1:0] op, input logic [7:0] b,
                             input logic [9:0] idx, output frame_report_type rep);
      rep = '0;
      if (op == bfr_pkg::BFR_OP_BYTE) begin
         if (cfg.timeout_ticks != 0 && p_ticks >= cfg.timeout_ticks)
            p_state = bfr_pkg::BFR_HUNT;
         if (p_state >= bfr_pkg::BFR_COMPLETE) p_state = bfr_pkg::BFR_HUNT;
         case (p_state)
            bfr_pkg::BFR_HUNT: begin
               if (b == cfg.sync_first) begin
                  p_state = bfr_pkg::BFR_SYNC2;
                  p_ticks = '0;
               end
            end
            bfr_pkg::BFR_SYNC2: begin
               p_state = (b == cfg.sync_second) ? bfr_pkg::BFR_LEN : bfr_pkg::BFR_ERROR;
            end
            bfr_pkg::BFR_LEN: begin
               if (b[7]) begin
                  p_pos   = {8'd0, b[6:0]};
                  p_state = bfr_pkg::BFR_LEN2;
               end else begin
                  take_length(int'(b));
               end
            end
            bfr_pkg::BFR_LEN2: take_length(int'(p_pos[6:0]) * 256 + int'(b));
            bfr_pkg::BFR_PAYLOAD: begin
               if (p_pos < MAX_PAYLOAD) begin
                  p_store[p_pos[9:0]] = b;
                  if (int'(p_pos) + 1 > store_top) store_top = int'(p_pos) + 1;
               end
               p_xor = p_xor ^ b;
               if (int'(p_pos) + 1 >= int'(p_len)) p_state = bfr_pkg::BFR_CHECK;
               p_pos = p_pos + 15'd1;
            end
            bfr_pkg::BFR_CHECK: begin
               p_state = (b == p_xor) ? bfr_pkg::BFR_COMPLETE : bfr_pkg::BFR_CKERROR;
            end
            default: p_state = bfr_pkg::BFR_HUNT;
         endcase
      end else if (op == bfr_pkg::BFR_OP_TICK) begin
         if (p_ticks < bfr_pkg::BFR_TICK_MAX) p_ticks = p_ticks + 16'd1;
      end else if (op == bfr_pkg::BFR_OP_READ) begin
         rep.read_data = p_store[idx];
      end
      rep.status       = p_state;
      rep.frame_length = p_len;
   endtask

   // scoreboard: predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin : watch
      frame_report_type seen, want, pred;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status       = rsp_tdata[3:0];
            seen.frame_length = rsp_tdata[14:4];
            seen.read_data    = rsp_tdata[22:15];
            if (expected_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected response: status %0d len %0d data %02h",
                           seen.status, seen.frame_length, seen.read_data);
            end else begin
               want = expected_reports.pop_front();
               if (seen.status != want.status || seen.frame_length != want.frame_length
                   || seen.read_data != want.read_data) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch: want status %0d len %0d data %02h, got %0d %0d %02h",
                              want.status, want.frame_length, want.read_data,
                              seen.status, seen.frame_length, seen.read_data);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            parse_step(req_tuser, req_tdata[7:0], req_tdata[17:8], pred);
            expected_reports.push_back(typed_valid ? typed_report : pred);
         end
      end
   end

   // response back-pressure: a 16-bit stall pattern, reloaded whenever ready_phase wraps
   logic [15:0] ready_pattern = 16'hFFFF;
   logic [6:0]  ready_phase = '0;
   always @(negedge clock) begin
      ready_phase <= ready_phase + 7'd1;
      if (ready_phase == 0)
         ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      rsp_tready <= ready_pattern[ready_phase[3:0]];
   end

   // one request; called and returns at a falling edge
   task automatic put(input logic [1:0] op, input logic [7:0] b, input logic [9:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 7) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(64, 256);
         end else begin
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, idx, b};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      item_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      put(bfr_pkg::BFR_OP_BYTE, b, 10'($urandom));
   endtask

   task automatic send_read();
      put(bfr_pkg::BFR_OP_READ, 8'($urandom), 10'($urandom_range(0, store_top - 1)));
   endtask

   // occasional tick, read-back or dead op between bytes
   task automatic sprinkle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) put(bfr_pkg::BFR_OP_TICK, 8'($urandom), 10'($urandom));
      else if (r < 10 && store_top > 0) send_read();
      else if (r == 10) put(OP_UNUSED, 8'($urandom), 10'($urandom));
   endtask

   task automatic send_frame(input int len, input bit long_form, input bit good_sum);
      logic [7:0]  sum, b;
      logic [14:0] l15;
      l15 = 15'(len);
      sum = '0;
      send_byte(cfg.sync_first);
      sprinkle();
      send_byte(cfg.sync_second);
      sprinkle();
      if (long_form) begin
         send_byte({1'b1, l15[14:8]});
         sprinkle();
         send_byte(l15[7:0]);
      end else begin
         send_byte({1'b0, l15[6:0]});
      end
      for (int i = 0; i < len; i++) begin
         b   = 8'($urandom);
         sum = sum ^ b;
         send_byte(b);
         sprinkle();
      end
      send_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
   endtask

   // garbage, broken headers, truncated frames and stray requests
   task automatic send_noise();
      int n, hi;
      case ($urandom_range(0, 6))
         0: begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom));
         end
         1: begin
            send_byte(cfg.sync_first);
            send_byte(cfg.sync_second ^ 8'($urandom_range(1, 255)));
         end
         2: begin
            send_byte(cfg.sync_first);
            send_byte(cfg.sync_second);
            case ($urandom_range(0, 2))
               0: send_byte(8'h00);
               1: begin
                  send_byte(8'h80);
                  send_byte(8'h00);
               end
               default: begin
                  // long form above the buffer size
                  hi = $urandom_range(4, 127);
                  send_byte(8'h80 | 8'(hi));
                  send_byte((hi == 4) ? 8'($urandom_range(1, 255)) : 8'($urandom));
               end
            endcase
         end
         3: begin
            send_byte(cfg.sync_first);
            send_byte(cfg.sync_second);
            send_byte(8'($urandom_range(5, 40)));
            n = $urandom_range(0, 4);
            repeat (n) send_byte(8'($urandom));
         end
         4: begin
            n = $urandom_range(1, 8);
            repeat (n) put(bfr_pkg::BFR_OP_TICK, 8'($urandom), 10'($urandom));
         end
         5: begin
            n = $urandom_range(1, 4);
            if (store_top > 0) repeat (n) send_read();
         end
         default: put(OP_UNUSED, 8'($urandom), 10'($urandom));
      endcase
   endtask

   // hold the sender until every outstanding request has its response
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic run_traffic(input int n);
      int stop_at, next_pause, r, len;
      bit long_form;
      stop_at    = item_count + n;
      next_pause = item_count + $urandom_range(60, 140);
      while (item_count < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 19);
            if (r < 14) len = $urandom_range(1, 16);
            else if (r < 17) len = $urandom_range(17, 127);
            else len = $urandom_range(1, 300);
            long_form = (len > 127) || ($urandom_range(0, 3) == 0);
            send_frame(len, long_form, $urandom_range(0, 7) != 0);
         end else begin
            send_noise();
         end
         if (item_count >= next_pause) begin
            settle();
            next_pause = item_count + $urandom_range(60, 140);
         end
      end
   endtask

   // idle only; csr_we is held across the three writes and dropped once
   task automatic configure(input logic [7:0] first, input logic [7:0] second,
                            input logic [15:0] ticks);
      csr_we    <= 1'b1;
      csr_index <= bfr_pkg::BFR_REG_SYNC_FIRST;
      csr_wdata <= {8'($urandom), first};
      @(negedge clock);
      csr_index <= bfr_pkg::BFR_REG_SYNC_SECOND;
      csr_wdata <= {8'($urandom), second};
      @(negedge clock);
      csr_index <= bfr_pkg::BFR_REG_TIMEOUT_TICKS;
      csr_wdata <= ticks;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg.sync_first    = first;
      cfg.sync_second   = second;
      cfg.timeout_ticks = ticks;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [7:0] v;
      int         waited;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      typed_valid = 1'b0;
      typed_report = '0;
      fault_count = 0;
      item_count  = 0;
      burst_left  = 0;
      store_top   = 0;
      cfg.sync_first    = bfr_pkg::BFR_SYNC_FIRST_RST;
      cfg.sync_second   = bfr_pkg::BFR_SYNC_SECOND_RST;
      cfg.timeout_ticks = bfr_pkg::BFR_TIMEOUT_TICKS_RST;
      p_state = bfr_pkg::BFR_HUNT;
      p_pos   = '0;
      p_len   = '0;
      p_xor   = '0;
      p_ticks = '0;

      directed_rows = '{
         '{OP_UNUSED,            8'h00, 10'h000, 1'b1, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_TICK, 8'h00, 10'h000, 1'b1, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'hA5, 10'h000, 1'b1, bfr_pkg::BFR_SYNC2, 11'd0, 8'h00},
         // bad 2nd sync
         '{bfr_pkg::BFR_OP_BYTE, 8'h00, 10'h000, 1'b1, bfr_pkg::BFR_ERROR, 11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'hA5, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h5A, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         // zero short
         '{bfr_pkg::BFR_OP_BYTE, 8'h00, 10'h000, 1'b1, bfr_pkg::BFR_ERROR, 11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'hA5, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h5A, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h80, 10'h000, 1'b1, bfr_pkg::BFR_LEN2,  11'd0, 8'h00},
         // zero long
         '{bfr_pkg::BFR_OP_BYTE, 8'h00, 10'h000, 1'b1, bfr_pkg::BFR_ERROR, 11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'hA5, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h5A, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h84, 10'h000, 1'b1, bfr_pkg::BFR_LEN2,  11'd0, 8'h00},
         // 1025
         '{bfr_pkg::BFR_OP_BYTE, 8'h01, 10'h000, 1'b1, bfr_pkg::BFR_ERROR, 11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'hA5, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h5A, 10'h000, 1'b0, bfr_pkg::BFR_HUNT,  11'd0, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h02, 10'h000, 1'b1, bfr_pkg::BFR_PAYLOAD, 11'd2, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'hFF, 10'h000, 1'b1, bfr_pkg::BFR_PAYLOAD, 11'd2, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'h0F, 10'h000, 1'b1, bfr_pkg::BFR_CHECK, 11'd2, 8'h00},
         '{bfr_pkg::BFR_OP_BYTE, 8'hF0, 10'h000, 1'b1, bfr_pkg::BFR_COMPLETE, 11'd2, 8'h00},
         '{bfr_pkg::BFR_OP_READ, 8'h00, 10'h000, 1'b1, bfr_pkg::BFR_COMPLETE, 11'd2, 8'hFF},
         '{bfr_pkg::BFR_OP_READ, 8'h00, 10'h001, 1'b1, bfr_pkg::BFR_COMPLETE, 11'd2, 8'h0F},
         '{OP_UNUSED,            8'hFF, 10'h3FF, 1'b1, bfr_pkg::BFR_COMPLETE, 11'd2, 8'h00}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         typed_valid               = directed_rows[i].typed;
         typed_report.status       = directed_rows[i].status;
         typed_report.frame_length = directed_rows[i].length;
         typed_report.read_data    = directed_rows[i].data;
         put(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].idx);
      end
      typed_valid = 1'b0;

      // one long-form frame up front so reads spread over a wide span
      send_frame(200, 1'b1, 1'b1);
      run_traffic(100);
      settle();

      configure(8'h00, 8'hFF, 16'd1);
      run_traffic(100);
      settle();

      // longest timeout: a short run of ticks must not fire it
      configure(8'hFF, 8'h00, 16'hFFFF);
      send_frame(3, 1'b0, 1'b1);
      send_byte(cfg.sync_first);
      repeat (20) put(bfr_pkg::BFR_OP_TICK, 8'($urandom), 10'($urandom));
      send_byte(cfg.sync_second);
      run_traffic(100);
      settle();

      configure(8'($urandom), 8'($urandom), 16'($urandom_range(2, 40)));
      run_traffic(100);
      settle();

      // both sync bytes equal
      v = 8'($urandom);
      configure(v, v, 16'd0);
      run_traffic(100);

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_reports.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
      fault_count += expected_reports.size();
      if (fault_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bfr_pkg.sv
hdl/bfr_store.sv
hdl/bfr_parser.sv
hdl/binary_frame_receiver_top.sv
bench/testbench.sv
